>>> src/wpt_pkg.sv
package wpt_pkg;

   // Default sizes of the path table and of the search window.
   localparam int PATH_DEPTH_DEF = 256;
   localparam int MAX_WINDOW_DEF = 16;

   // Configuration register reset values.
   localparam logic [15:0] GAIN_KP_RST     = 16'd2355;
   localparam logic [22:0] SOFT_OFFSET_RST = 23'd26214;
   localparam logic [14:0] STEER_LIMIT_RST = 15'd2859;
   localparam logic [22:0] JUMP_LIMIT_RST  = 23'd32768;
   localparam logic [3:0]  WINDOW_RST      = 4'd9;
   localparam logic [8:0]  PATH_LEN_RST    = 9'd160;

   // Configuration port shape.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   // Angle constants in Q2.13 and Q2.30.
   localparam logic signed [16:0] PI_Q13     = 17'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;

   // CORDIC datapath sizes.
   localparam int CORDIC_W     = 52;
   localparam int CORDIC_ZW    = 35;
   localparam int CORDIC_STEPS = 28;

   // Square root sizes: 50-bit radicand, 25-bit root.
   localparam int RAD_W  = 50;
   localparam int ROOT_W = 25;

   // Path table word: x, y, heading.
   localparam int WORD_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_KP     = 3'd0,
      CSR_SOFT_OFFSET = 3'd1,
      CSR_STEER_LIMIT = 3'd2,
      CSR_JUMP_LIMIT  = 3'd3,
      CSR_WINDOW      = 3'd4,
      CSR_PATH_LEN    = 3'd5
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILTER,
      ST_RD,
      ST_WAIT,
      ST_CMP,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_MUL,
      ST_CORR_GO,
      ST_CORR_WAIT,
      ST_BEAR_GO,
      ST_BEAR_WAIT,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_FINISH
   } st_type;

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_RUN,
      UNIT_DONE
   } unit_state_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

>>> src/wpt_req_if.sv
interface wpt_req_if;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [7:0]        wp_slot;
   logic signed [23:0] wp_x;
   logic signed [23:0] wp_y;
   logic signed [15:0] wp_heading;
   logic signed [23:0] meas_x;
   logic signed [23:0] meas_y;
   logic signed [15:0] imu_heading;

   modport source(
      output valid, req_type, wp_slot, wp_x, wp_y, wp_heading, meas_x, meas_y, imu_heading,
      input  ready
   );
   modport sink(
      input  valid, req_type, wp_slot, wp_x, wp_y, wp_heading, meas_x, meas_y, imu_heading,
      output ready
   );
endinterface

>>> src/wpt_rsp_if.sv
interface wpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] steer_cmd;
   logic [23:0]        min_distance;
   logic [7:0]         nearest_index;
   logic signed [15:0] heading_error;
   logic signed [23:0] filtered_x;
   logic signed [23:0] filtered_y;

   modport source(
      output valid, steer_cmd, min_distance, nearest_index, heading_error,
             filtered_x, filtered_y,
      input  ready
   );
   modport sink(
      input  valid, steer_cmd, min_distance, nearest_index, heading_error,
             filtered_x, filtered_y,
      output ready
   );
endinterface

>>> src/wpt_ram.sv
module wpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/wpt_sqrt.sv
module wpt_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wpt_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [wpt_pkg::ROOT_W-1:0]    root
);
   import wpt_pkg::*;

   unit_state_type      state_ff, state_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [ROOT_W+1:0]   rem_try;
   logic [ROOT_W+1:0]   trial;

   // One root bit per cycle: bring down two radicand bits and try a subtraction.
   always_comb begin
      state_in = state_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      rem_try  = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial    = {root_ff, 2'b01};
      case (state_ff)
         UNIT_IDLE: begin
            if (start) begin
               rad_in   = radicand;
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = UNIT_RUN;
            end
         end
         UNIT_RUN: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_try >= trial) begin
               rem_in  = rem_try - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_try;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_W - 1)) begin
               state_in = UNIT_DONE;
            end
         end
         UNIT_DONE: begin
            done     = 1'b1;
            state_in = UNIT_IDLE;
         end
         default: begin
            state_in = UNIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
endmodule

>>> src/wpt_cordic.sv
module wpt_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wpt_pkg::CORDIC_W-1:0] y_arg,
   input  logic signed [wpt_pkg::CORDIC_W-1:0] x_arg,
   output logic                                done,
   output logic signed [16:0]                  angle
);
   import wpt_pkg::*;

   unit_state_type              state_ff, state_in;
   logic signed [CORDIC_W-1:0]  x_ff, x_in;
   logic signed [CORDIC_W-1:0]  y_ff, y_in;
   logic signed [CORDIC_ZW-1:0] z_ff, z_in;
   logic signed [CORDIC_ZW-1:0] base_ff, base_in;
   logic                        zero_ff, zero_in;
   logic [4:0]                  step_ff, step_in;
   logic signed [CORDIC_W-1:0]  dx;
   logic signed [CORDIC_W-1:0]  dy;
   logic signed [CORDIC_ZW-1:0] tab;
   logic signed [CORDIC_ZW-1:0] sum;

   // Vectoring mode, one micro-rotation per cycle, after a half-plane fold.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      base_in  = base_ff;
      zero_in  = zero_ff;
      step_in  = step_ff;
      done     = 1'b0;
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      tab      = $signed({5'b0, atan_entry(step_ff)});
      case (state_ff)
         UNIT_IDLE: begin
            if (start) begin
               zero_in = (y_arg == '0) && !x_arg[CORDIC_W-1];
               if (x_arg[CORDIC_W-1]) begin
                  x_in    = -x_arg;
                  y_in    = -y_arg;
                  base_in = y_arg[CORDIC_W-1] ? -PI_Q30 : PI_Q30;
               end else begin
                  x_in    = x_arg;
                  y_in    = y_arg;
                  base_in = '0;
               end
               z_in     = '0;
               step_in  = '0;
               state_in = UNIT_RUN;
            end
         end
         UNIT_RUN: begin
            if (y_ff > 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + tab;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - tab;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = UNIT_DONE;
            end
         end
         UNIT_DONE: begin
            done     = 1'b1;
            state_in = UNIT_IDLE;
         end
         default: begin
            state_in = UNIT_IDLE;
         end
      endcase
   end

   // Round Q2.30 to Q2.13.
   assign sum   = base_ff + z_ff + CORDIC_ZW'(65536);
   assign angle = zero_ff ? 17'sd0 : 17'(sum >>> 17);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      base_ff <= base_in;
      zero_ff <= zero_in;
      step_ff <= step_in;
   end
endmodule

>>> src/waypoint_path_tracking_steering.sv
// Waypoint path tracking steering. A load transfer writes one waypoint into the path
// table without leaving the idle state. A sample transfer negates x, rejects per-axis jumps
// beyond jump_limit, searches the current waypoint and up to window_ahead waypoints after
// it for the nearest, and returns one result with the steering command, distance, index,
// wrapped heading error and filtered position. A sample examines 1 to MAX_WINDOW waypoints.
// The search reads the table one entry at a time through its single port (states ST_RD,
// ST_WAIT, ST_CMP), the square root yields one bit per cycle, and one shared CORDIC unit
// runs 28 steps for the correction angle and again for the bearing. One sample is worked
// on at a time; a finished result waits in an output register so the next transfer can be
// taken. The path table has no reset.
module waypoint_path_tracking_steering #(
   parameter int PATH_DEPTH = wpt_pkg::PATH_DEPTH_DEF,
   parameter int MAX_WINDOW = wpt_pkg::MAX_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wpt_req_if.sink                        req,
   wpt_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [wpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wpt_pkg::*;

   localparam int AW = $clog2(PATH_DEPTH);
   localparam int IW = ((AW > 9) ? AW : 9) + 2;

   // Configuration registers.
   logic [15:0] gain_kp_ff;
   logic [22:0] soft_offset_ff;
   logic [14:0] steer_limit_ff;
   logic [22:0] jump_limit_ff;
   logic [3:0]  window_ff;
   logic [8:0]  path_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_kp_ff     <= GAIN_KP_RST;
         soft_offset_ff <= SOFT_OFFSET_RST;
         steer_limit_ff <= STEER_LIMIT_RST;
         jump_limit_ff  <= JUMP_LIMIT_RST;
         window_ff      <= WINDOW_RST;
         path_len_ff    <= PATH_LEN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_KP:     gain_kp_ff     <= csr_wdata[15:0];
            CSR_SOFT_OFFSET: soft_offset_ff <= csr_wdata[22:0];
            CSR_STEER_LIMIT: steer_limit_ff <= csr_wdata[14:0];
            CSR_JUMP_LIMIT:  jump_limit_ff  <= csr_wdata[22:0];
            CSR_WINDOW:      window_ff      <= csr_wdata[3:0];
            CSR_PATH_LEN:    path_len_ff    <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   st_type              state_ff, state_in;
   logic signed [23:0]  meas_x_ff, meas_x_in;
   logic signed [23:0]  meas_y_ff, meas_y_in;
   logic signed [15:0]  imu_ff, imu_in;
   logic signed [23:0]  last_x_ff, last_x_in;
   logic signed [23:0]  last_y_ff, last_y_in;
   logic [AW-1:0]       cur_idx_ff, cur_idx_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [IW-1:0]       stop_ff, stop_in;
   logic                first_ff, first_in;
   logic [RAD_W-1:0]    sqx_ff, sqx_in;
   logic [RAD_W-1:0]    sqy_ff, sqy_in;
   logic [RAD_W-1:0]    best_ff, best_in;
   logic [23:0]         dmin_ff, dmin_in;
   logic [39:0]         prod_ff, prod_in;
   logic signed [16:0]  corr_ff, corr_in;
   logic signed [16:0]  bear_ff, bear_in;
   logic signed [15:0]  theta_ff, theta_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [16:0]  out_steer_ff, out_steer_in;
   logic [23:0]         out_dist_ff, out_dist_in;
   logic [7:0]          out_idx_ff, out_idx_in;
   logic signed [15:0]  out_herr_ff, out_herr_in;
   logic signed [23:0]  out_x_ff, out_x_in;
   logic signed [23:0]  out_y_ff, out_y_in;

   // Path table and arithmetic units.
   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic [WORD_W-1:0]   ram_wdata;
   logic [WORD_W-1:0]   ram_rdata;
   logic                sqrt_start;
   logic                sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;
   logic                cor_start;
   logic signed [CORDIC_W-1:0] cor_y;
   logic signed [CORDIC_W-1:0] cor_x;
   logic                cor_done;
   logic signed [16:0]  cor_angle;

   wpt_ram #(.WIDTH(WORD_W), .DEPTH(PATH_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   wpt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (best_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   wpt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .y_arg (cor_y),
      .x_arg (cor_x),
      .done  (cor_done),
      .angle (cor_angle)
   );

   // Working values of the sequencer.
   logic signed [23:0]  mx;
   logic signed [25:0]  ddx;
   logic signed [25:0]  ddy;
   logic [25:0]         adx;
   logic [25:0]         ady;
   logic                reject;
   logic [IW-1:0]       len;
   logic [IW-1:0]       win;
   logic [IW-1:0]       stop_sum;
   logic [IW-1:0]       scan_next;
   logic signed [24:0]  ex;
   logic signed [24:0]  ey;
   logic [24:0]         aex;
   logic [24:0]         aey;
   logic [RAD_W-1:0]    dsum;
   logic [22:0]         off;
   logic signed [16:0]  lim;
   logic signed [17:0]  bdiff;
   logic signed [18:0]  steer_raw;
   logic signed [16:0]  herr_raw;
   logic signed [17:0]  herr_wrap;
   logic                out_free;

   always_comb begin
      state_in     = state_ff;
      meas_x_in    = meas_x_ff;
      meas_y_in    = meas_y_ff;
      imu_in       = imu_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      cur_idx_in   = cur_idx_ff;
      scan_in      = scan_ff;
      stop_in      = stop_ff;
      first_in     = first_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      best_in      = best_ff;
      dmin_in      = dmin_ff;
      prod_in      = prod_ff;
      corr_in      = corr_ff;
      bear_in      = bear_ff;
      theta_in     = theta_ff;
      out_free     = !rsp_valid_ff || rsp.ready;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_steer_in = out_steer_ff;
      out_dist_in  = out_dist_ff;
      out_idx_in   = out_idx_ff;
      out_herr_in  = out_herr_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      ram_we       = 1'b0;
      ram_addr     = scan_ff[AW-1:0];
      ram_wdata    = {req.wp_x, req.wp_y, req.wp_heading};
      sqrt_start   = 1'b0;
      cor_start    = 1'b0;
      off          = (soft_offset_ff == '0) ? 23'd1 : soft_offset_ff;
      cor_y        = CORDIC_W'({prod_ff, 8'b0});
      cor_x        = CORDIC_W'({off, 20'b0});
      req.ready    = (state_ff == ST_IDLE);

      // Jump rejection on the negated x and on y.
      mx     = (meas_x_ff == 24'sh800000) ? 24'sh7fffff : -meas_x_ff;
      ddx    = 26'(mx) - 26'(last_x_ff);
      ddy    = 26'(meas_y_ff) - 26'(last_y_ff);
      adx    = ddx[25] ? 26'(-ddx) : 26'(ddx);
      ady    = ddy[25] ? 26'(-ddy) : 26'(ddy);
      reject = (adx > {3'b0, jump_limit_ff}) || (ady > {3'b0, jump_limit_ff});

      // Search bounds.
      len      = (IW'(path_len_ff) > IW'(PATH_DEPTH)) ? IW'(PATH_DEPTH) : IW'(path_len_ff);
      win      = (IW'(window_ff) > IW'(MAX_WINDOW - 1)) ? IW'(MAX_WINDOW - 1)
                                                         : IW'(window_ff);
      stop_sum = IW'(cur_idx_ff) + win + IW'(1);
      scan_next = scan_ff + IW'(1);

      // Distance terms of the entry just read.
      ex   = 25'(last_x_ff) - 25'($signed(ram_rdata[63:40]));
      ey   = 25'(last_y_ff) - 25'($signed(ram_rdata[39:16]));
      aex  = ex[24] ? 25'(-ex) : 25'(ex);
      aey  = ey[24] ? 25'(-ey) : 25'(ey);
      dsum = sqx_ff + sqy_ff;

      // Output arithmetic.
      lim       = $signed({2'b0, steer_limit_ff});
      bdiff     = 18'(bear_ff) - 18'(theta_ff);
      herr_raw  = 17'(theta_ff) - 17'(imu_ff);
      if (bdiff >= 0) begin
         steer_raw = 19'(herr_raw) - 19'(corr_ff);
      end else begin
         steer_raw = 19'(herr_raw) + 19'(corr_ff);
      end
      if (herr_raw < -PI_Q13) begin
         herr_wrap = 18'(herr_raw) + TWO_PI_Q13;
      end else if (herr_raw > PI_Q13) begin
         herr_wrap = 18'(herr_raw) - TWO_PI_Q13;
      end else begin
         herr_wrap = 18'(herr_raw);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req_kind_type'(req.req_type) == REQ_LOAD) begin
                  ram_addr = AW'(req.wp_slot);
                  ram_we   = (IW'(req.wp_slot) < IW'(PATH_DEPTH));
               end else begin
                  meas_x_in = req.meas_x;
                  meas_y_in = req.meas_y;
                  imu_in    = req.imu_heading;
                  state_in  = ST_FILTER;
               end
            end
         end
         ST_FILTER: begin
            if (!reject) begin
               last_x_in = mx;
               last_y_in = meas_y_ff;
            end
            scan_in  = IW'(cur_idx_ff);
            stop_in  = (stop_sum > len) ? len : stop_sum;
            first_in = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            sqx_in   = RAD_W'(aex * aex);
            sqy_in   = RAD_W'(aey * aey);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            first_in = 1'b0;
            if (first_ff || (dsum < best_ff)) begin
               best_in = dsum;
               if (!first_ff) begin
                  cur_idx_in = scan_ff[AW-1:0];
               end
            end
            scan_in = scan_next;
            if (scan_next < stop_ff) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_SQRT_GO;
            end
         end
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               dmin_in  = sqrt_root[ROOT_W-1] ? 24'hffffff : sqrt_root[23:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 40'(gain_kp_ff * dmin_ff);
            state_in = ST_CORR_GO;
         end
         ST_CORR_GO: begin
            cor_start = 1'b1;
            state_in  = ST_CORR_WAIT;
         end
         ST_CORR_WAIT: begin
            if (cor_done) begin
               if (cor_angle > lim) begin
                  corr_in = lim;
               end else if (cor_angle < -lim) begin
                  corr_in = -lim;
               end else begin
                  corr_in = cor_angle;
               end
               state_in = ST_BEAR_GO;
            end
         end
         ST_BEAR_GO: begin
            cor_y     = CORDIC_W'(last_y_ff) <<< 24;
            cor_x     = CORDIC_W'(last_x_ff) <<< 24;
            cor_start = 1'b1;
            state_in  = ST_BEAR_WAIT;
         end
         ST_BEAR_WAIT: begin
            if (cor_done) begin
               bear_in  = cor_angle;
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            ram_addr = cur_idx_ff;
            state_in = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: begin
            theta_in = $signed(ram_rdata[15:0]);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (steer_raw > 19'sd65535) begin
                  out_steer_in = 17'sd65535;
               end else if (steer_raw < -19'sd65536) begin
                  out_steer_in = -17'sd65536;
               end else begin
                  out_steer_in = 17'(steer_raw);
               end
               out_dist_in = dmin_ff;
               out_idx_in  = 8'(cur_idx_ff);
               out_herr_in = 16'(herr_wrap);
               out_x_in    = last_x_ff;
               out_y_in    = last_y_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         cur_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         cur_idx_ff   <= cur_idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      meas_x_ff    <= meas_x_in;
      meas_y_ff    <= meas_y_in;
      imu_ff       <= imu_in;
      scan_ff      <= scan_in;
      stop_ff      <= stop_in;
      first_ff     <= first_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      best_ff      <= best_in;
      dmin_ff      <= dmin_in;
      prod_ff      <= prod_in;
      corr_ff      <= corr_in;
      bear_ff      <= bear_in;
      theta_ff     <= theta_in;
      out_steer_ff <= out_steer_in;
      out_dist_ff  <= out_dist_in;
      out_idx_ff   <= out_idx_in;
      out_herr_ff  <= out_herr_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.steer_cmd     = out_steer_ff;
   assign rsp.min_distance  = out_dist_ff;
   assign rsp.nearest_index = out_idx_ff;
   assign rsp.heading_error = out_herr_ff;
   assign rsp.filtered_x    = out_x_ff;
   assign rsp.filtered_y    = out_y_ff;
endmodule
